### src/rrcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrcl_pkg
// Shared types and field widths of the remote command latch.
// ---------------------------------------------------------------------------
package rrcl_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DRIVE_W = 16;
	localparam int unsigned TIMER_W = 16;

	// Register index on the configuration port
	typedef enum logic [1:0] {
		CFG_AUTH_KEY        = 2'd0,
		CFG_RELEASE_TIMEOUT = 2'd1,
		CFG_FRAME_PERIOD    = 2'd2
	} cfg_index_t;

	// Job handed from the front end to the output sequencer
	typedef struct packed {
		logic               frame;   // emit five frame bytes instead of one status
		logic [DRIVE_W-1:0] drive;   // drive word after the item
		logic               lamp;    // indicator lamp after the item
	} rrcl_job_t;

endpackage : rrcl_pkg
`default_nettype wire

### src/rrcl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrcl_front
// Accepts messages and millisecond ticks, updates latches, drive word,
// timers and lamp, and posts one output job per transaction.
// ---------------------------------------------------------------------------
module rrcl_front
	import rrcl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [TIMER_W-1:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [BYTE_W-1:0]  auth_byte,
	input  wire logic [BYTE_W-1:0]  command,
	input  wire logic               long_enough,
	input  wire logic               q_full,
	output logic                    q_push,
	output rrcl_job_t               q_job
);

	// Key codes
	localparam logic [BYTE_W-1:0] CMD_RELEASE = 8'd0;
	localparam logic [BYTE_W-1:0] CMD_AUTO    = 8'd72;
	localparam logic [BYTE_W-1:0] CMD_MACHINE = 8'd80;
	localparam logic [BYTE_W-1:0] CMD_TANK    = 8'd70;
	localparam logic [BYTE_W-1:0] CMD_B1      = 8'd71;
	localparam logic [BYTE_W-1:0] CMD_B2      = 8'd79;
	localparam logic [BYTE_W-1:0] CMD_B3      = 8'd75;
	localparam logic [BYTE_W-1:0] CMD_B4      = 8'd76;
	localparam logic [BYTE_W-1:0] CMD_B7      = 8'd78;
	localparam logic [BYTE_W-1:0] CMD_B8      = 8'd74;
	localparam logic [BYTE_W-1:0] CMD_B9      = 8'd69;
	localparam logic [BYTE_W-1:0] CMD_B10     = 8'd73;
	localparam logic [BYTE_W-1:0] CMD_B15     = 8'd77;

	// Drive word bit positions
	localparam int unsigned BIT_AUTO     = 0;
	localparam int unsigned BIT_TANK_ON  = 5;
	localparam int unsigned BIT_TANK_OFF = 6;
	localparam int unsigned BIT_MACHINE  = 13;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	logic [BYTE_W-1:0]  auth_key_q;
	logic [TIMER_W-1:0] release_timeout_q;
	logic [TIMER_W-1:0] frame_period_q;

	logic               auto_q, machine_q, tank_q, pressed_q, lamp_q;
	logic [BYTE_W-1:0]  last_cmd_q;
	logic [DRIVE_W-1:0] drive_q;
	logic [TIMER_W-1:0] silence_q, frame_q;

	logic               auto_d, machine_d, tank_d, pressed_d, lamp_d;
	logic [BYTE_W-1:0]  last_cmd_d;
	logic [DRIVE_W-1:0] drive_d;
	logic [TIMER_W-1:0] silence_d, frame_d;
	logic               frame_due;
	logic               accept;

	// Drive word shown after a release: only the latch bits remain
	function automatic logic [DRIVE_W-1:0] release_word(input logic a, input logic m,
			input logic t);
		logic [DRIVE_W-1:0] w;
		w               = '0;
		w[BIT_AUTO]     = a;
		w[BIT_MACHINE]  = m;
		w[BIT_TANK_ON]  = t;
		w[BIT_TANK_OFF] = ~t;
		return w;
	endfunction

	assign in_ready = ~q_full;
	assign accept   = in_valid & ~q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auth_key_q        <= 8'd100;
			release_timeout_q <= 16'd200;
			frame_period_q    <= 16'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AUTH_KEY:        auth_key_q        <= cfg_data[BYTE_W-1:0];
				CFG_RELEASE_TIMEOUT: release_timeout_q <= cfg_data;
				CFG_FRAME_PERIOD:    frame_period_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state for one transaction
	always_comb begin
		auto_d     = auto_q;
		machine_d  = machine_q;
		tank_d     = tank_q;
		pressed_d  = pressed_q;
		lamp_d     = lamp_q;
		last_cmd_d = last_cmd_q;
		drive_d    = drive_q;
		silence_d  = silence_q;
		frame_d    = frame_q;
		frame_due  = 1'b0;
		if (!func) begin
			if (long_enough && (auth_byte == auth_key_q)) begin
				lamp_d    = 1'b1;
				silence_d = '0;
				if (command != last_cmd_q) begin
					last_cmd_d = command;
					if (command == CMD_RELEASE) begin
						drive_d   = release_word(auto_q, machine_q, tank_q);
						pressed_d = 1'b0;
					end else if (!pressed_q) begin
						pressed_d = 1'b1;
						case (command)
							CMD_AUTO: begin
								auto_d            = ~auto_q;
								drive_d[BIT_AUTO] = ~auto_q;
							end
							CMD_MACHINE: begin
								machine_d            = ~machine_q;
								drive_d[BIT_MACHINE] = ~machine_q;
							end
							CMD_TANK: begin
								tank_d                = ~tank_q;
								drive_d[BIT_TANK_ON]  = ~tank_q;
								drive_d[BIT_TANK_OFF] = tank_q;
							end
							CMD_B1:  drive_d[1]  = 1'b1;
							CMD_B2:  drive_d[2]  = 1'b1;
							CMD_B3:  drive_d[3]  = 1'b1;
							CMD_B4:  drive_d[4]  = 1'b1;
							CMD_B7:  drive_d[7]  = 1'b1;
							CMD_B8:  drive_d[8]  = 1'b1;
							CMD_B9:  drive_d[9]  = 1'b1;
							CMD_B10: drive_d[10] = 1'b1;
							CMD_B15: drive_d[15] = 1'b1;
							default: ;
						endcase
					end
				end
				if (command == CMD_RELEASE) lamp_d = 1'b0;
			end
		end else begin
			// advance both timers, saturating
			silence_d = (silence_q == TIMER_MAX) ? silence_q : silence_q + 16'd1;
			frame_d   = (frame_q == TIMER_MAX) ? frame_q : frame_q + 16'd1;
			if (silence_d >= release_timeout_q) begin
				if ((last_cmd_q != CMD_RELEASE) || pressed_q) begin
					drive_d    = release_word(auto_q, machine_q, tank_q);
					pressed_d  = 1'b0;
					last_cmd_d = CMD_RELEASE;
					lamp_d     = 1'b0;
				end
				silence_d = '0;
			end
			if (frame_d >= frame_period_q) begin
				frame_d   = '0;
				frame_due = 1'b1;
			end
		end
	end

	// Commit state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q     <= 1'b0;
			machine_q  <= 1'b0;
			tank_q     <= 1'b0;
			pressed_q  <= 1'b0;
			lamp_q     <= 1'b0;
			last_cmd_q <= 8'd255;
			drive_q    <= 16'h0040;
			silence_q  <= '0;
			frame_q    <= '0;
		end else if (accept) begin
			auto_q     <= auto_d;
			machine_q  <= machine_d;
			tank_q     <= tank_d;
			pressed_q  <= pressed_d;
			lamp_q     <= lamp_d;
			last_cmd_q <= last_cmd_d;
			drive_q    <= drive_d;
			silence_q  <= silence_d;
			frame_q    <= frame_d;
		end
	end

	// Post the job
	assign q_push      = accept;
	assign q_job.frame = frame_due;
	assign q_job.drive = drive_d;
	assign q_job.lamp  = lamp_d;

endmodule : rrcl_front
`default_nettype wire

### src/rrcl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrcl_queue
// Small job queue between the front end and the output sequencer.
// ---------------------------------------------------------------------------
module rrcl_queue
	import rrcl_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire rrcl_job_t  push_job,
	output logic            full,
	input  wire logic       pop,
	output rrcl_job_t       pop_job,
	output logic            empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rrcl_job_t         mem [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign pop_job = mem[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_job;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule : rrcl_queue
`default_nettype wire

### src/rrcl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrcl_back
// Output sequencer: turns each job into one status result or the five
// bytes of a status frame, through a registered output stage.
// ---------------------------------------------------------------------------
module rrcl_back
	import rrcl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire rrcl_job_t         q_job,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_frame,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   out_last,
	output logic                   out_led
);

	localparam logic [BYTE_W-1:0] HDR_0 = 8'd68;
	localparam logic [BYTE_W-1:0] HDR_1 = 8'd84;
	localparam logic [BYTE_W-1:0] HDR_2 = 8'd89;

	typedef enum logic [2:0] {
		BEAT_HDR0  = 3'd0,
		BEAT_HDR1  = 3'd1,
		BEAT_HDR2  = 3'd2,
		BEAT_LOW   = 3'd3,
		BEAT_HIGH  = 3'd4
	} beat_t;

	beat_t             beat_q;
	logic              valid_q, frame_q, last_q, led_q;
	logic [BYTE_W-1:0] byte_q;
	logic              load;
	logic              job_done;
	logic [BYTE_W-1:0] beat_byte;

	// Load a result whenever the output stage is free or being drained
	assign load     = ~q_empty & (~valid_q | out_ready);
	assign job_done = ~q_job.frame | (beat_q == BEAT_HIGH);
	assign q_pop    = load & job_done;

	// Select the frame byte of this beat
	always_comb begin
		case (beat_q)
			BEAT_HDR0: beat_byte = HDR_0;
			BEAT_HDR1: beat_byte = HDR_1;
			BEAT_HDR2: beat_byte = HDR_2;
			BEAT_LOW:  beat_byte = q_job.drive[BYTE_W-1:0];
			BEAT_HIGH: beat_byte = q_job.drive[DRIVE_W-1:BYTE_W];
			default:   beat_byte = '0;
		endcase
	end

	// Step through the beats of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q  <= BEAT_HDR0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q  <= job_done ? BEAT_HDR0 : beat_t'(beat_q + 3'd1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= q_job.frame;
			byte_q  <= q_job.frame ? beat_byte : '0;
			last_q  <= job_done;
			led_q   <= q_job.lamp;
		end
	end

	assign out_valid = valid_q;
	assign out_frame = frame_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_led   = led_q;

endmodule : rrcl_back
`default_nettype wire

### src/rf_remote_command_latch.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rf_remote_command_latch
// Radio remote receiver: key check, command latches and status frames.
// ---------------------------------------------------------------------------
// An input transaction is a radio message (tuser 0) or a millisecond tick
// (tuser 1). The front end handles it in the cycle it is accepted and takes
// a new one every cycle while its job queue (QUEUE_DEPTH entries) has room.
// Each message, and each tick with no frame due, yields one status result;
// a tick with a frame due yields five frame bytes, 68, 84, 89, drive bits
// 7:0 and drive bits 15:8, with tlast on the final one. The output port
// moves one result transaction per cycle while m_tready is high, and that
// port sets the sustained rate. Configuration writes take effect on the
// next transaction.
module rf_remote_command_latch
	import rrcl_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [TIMER_W-1:0] cfg_data,
	// input stream
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [23:0]        s_tdata,  // auth_byte[7:0], command[15:8], long_enough[16]
	input  wire logic               s_tuser,  // func
	// result stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,  // out_byte[7:0], indicator_led[8]
	output logic                    m_tuser,  // is_frame
	output logic                    m_tlast   // last_of_run
);

	rrcl_job_t         push_job, pop_job;
	logic              q_push, q_full, q_pop, q_empty;
	logic [BYTE_W-1:0] out_byte;
	logic              out_led;

	rrcl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.func        (s_tuser),
		.auth_byte   (s_tdata[7:0]),
		.command     (s_tdata[15:8]),
		.long_enough (s_tdata[16]),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	rrcl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	rrcl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_frame (m_tuser),
		.out_byte  (out_byte),
		.out_last  (m_tlast),
		.out_led   (out_led)
	);

	// Pack the result payload
	assign m_tdata = {7'd0, out_led, out_byte};

endmodule : rf_remote_command_latch
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the remote command latch.
// ---------------------------------------------------------------------------
// Radio messages and millisecond ticks go in on the input stream. A local
// model of the key check, the latches, the release timer and the frame timer
// predicts every status or frame byte. The predictions are queued and matched
// in order against the result stream. A directed pass covers rejection, the
// latch codes, repeats, unknown codes, the timeout release and frames. Random
// passes follow under changing register settings and handshake pressure.
// ---------------------------------------------------------------------------
module tb_top;
	import rrcl_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 11;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 50;

	localparam logic FUNC_MSG  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [7:0] CODE_RELEASE = 8'd0;
	localparam logic [7:0] CODE_AUTO    = 8'd72;
	localparam logic [7:0] CODE_MACHINE = 8'd80;
	localparam logic [7:0] CODE_TANK    = 8'd70;
	localparam logic [7:0] CODE_BIT1    = 8'd71;
	localparam logic [7:0] CODE_BIT2    = 8'd79;
	localparam logic [7:0] CODE_BIT3    = 8'd75;
	localparam logic [7:0] CODE_BIT4    = 8'd76;
	localparam logic [7:0] CODE_BIT7    = 8'd78;
	localparam logic [7:0] CODE_BIT8    = 8'd74;
	localparam logic [7:0] CODE_BIT9    = 8'd69;
	localparam logic [7:0] CODE_BIT10   = 8'd73;
	localparam logic [7:0] CODE_BIT15   = 8'd77;
	localparam logic [7:0] CODE_UNKNOWN = 8'd200;
	localparam logic [7:0] CODE_TOP     = 8'd255;

	localparam logic [7:0] KEY_DEFAULT = 8'd100;
	localparam logic [7:0] KEY_TOP     = 8'd255;
	localparam logic [7:0] HDR_0       = 8'd68;
	localparam logic [7:0] HDR_1       = 8'd84;
	localparam logic [7:0] HDR_2       = 8'd89;
	localparam logic [15:0] TIMER_SAT  = 16'hFFFF;
	localparam logic [15:0] DRIVE_IDLE = 16'h0040;

	typedef struct packed {
		logic       is_frame;
		logic [7:0] data;
		logic       last;
		logic       led;
	} status_t;

	// DUT ports
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	cfg_index_t          cfg_index = CFG_AUTH_KEY;
	logic [TIMER_W-1:0]  cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [23:0]         s_tdata   = '0;  // auth_byte[7:0], command[15:8], long_enough[16]
	logic                s_tuser   = 1'b0; // func
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [15:0]         m_tdata;          // out_byte[7:0], indicator_led[8]
	logic                m_tuser;          // is_frame
	logic                m_tlast;

	// Model state and its copy of the registers
	logic [7:0]  cur_key;
	logic [15:0] cur_timeout;
	logic [15:0] cur_period;
	logic        auto_on;
	logic        machine_on;
	logic        tank_on;
	logic        press_done;
	logic [7:0]  prev_cmd;
	logic [15:0] drive_word;
	logic [15:0] silence_cnt;
	logic [15:0] frame_cnt;
	logic        lamp_on;

	status_t status_q[$];
	int      errors        = 0;
	int      send_idle_pct = 0;
	int      stall_pct     = 0;
	int      hold_req      = 0;

	rf_remote_command_latch uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Latch model
	// -----------------------------------------------------------------------

	function automatic void reset_latch_model();
		cur_key     = KEY_DEFAULT;
		cur_timeout = 16'd200;
		cur_period  = 16'd50;
		auto_on     = 1'b0;
		machine_on  = 1'b0;
		tank_on     = 1'b0;
		press_done  = 1'b0;
		prev_cmd    = CODE_TOP;
		drive_word  = DRIVE_IDLE;
		silence_cnt = '0;
		frame_cnt   = '0;
		lamp_on     = 1'b0;
	endfunction

	// Clear momentary bits, keep only what the latches show
	function automatic void release_keys();
		drive_word = DRIVE_IDLE;
		if (auto_on) drive_word[0] = 1'b1;
		if (machine_on) drive_word[13] = 1'b1;
		if (tank_on) begin
			drive_word[6] = 1'b0;
			drive_word[5] = 1'b1;
		end
		press_done = 1'b0;
	endfunction

	function automatic void decode_press(logic [7:0] code);
		if (code == CODE_RELEASE) begin
			release_keys();
			return;
		end
		if (press_done) return;
		case (code)
			CODE_AUTO: begin
				auto_on = !auto_on;
				drive_word[0] = auto_on;
			end
			CODE_MACHINE: begin
				machine_on = !machine_on;
				drive_word[13] = machine_on;
			end
			CODE_TANK: begin
				tank_on = !tank_on;
				drive_word[5] = tank_on;
				drive_word[6] = !tank_on;
			end
			CODE_BIT1:  drive_word[1]  = 1'b1;
			CODE_BIT2:  drive_word[2]  = 1'b1;
			CODE_BIT3:  drive_word[3]  = 1'b1;
			CODE_BIT4:  drive_word[4]  = 1'b1;
			CODE_BIT7:  drive_word[7]  = 1'b1;
			CODE_BIT8:  drive_word[8]  = 1'b1;
			CODE_BIT9:  drive_word[9]  = 1'b1;
			CODE_BIT10: drive_word[10] = 1'b1;
			CODE_BIT15: drive_word[15] = 1'b1;
			default: ;
		endcase
		press_done = 1'b1;
	endfunction

	function automatic void push_status(logic is_frame, logic [7:0] data, logic last);
		status_t s;
		s.is_frame = is_frame;
		s.data     = data;
		s.last     = last;
		s.led      = lamp_on;
		status_q.push_back(s);
	endfunction

	// Advance the model by one accepted transaction and queue its results
	function automatic void predict_remote_step(logic func, logic [7:0] auth,
			logic [7:0] cmd, logic long_ok);
		if (func == FUNC_MSG) begin
			if (long_ok && auth == cur_key) begin
				lamp_on     = 1'b1;
				silence_cnt = '0;
				if (cmd != prev_cmd) begin
					decode_press(cmd);
					prev_cmd = cmd;
				end
				if (cmd == CODE_RELEASE) lamp_on = 1'b0;
			end
			push_status(1'b0, 8'd0, 1'b1);
		end else begin
			if (silence_cnt != TIMER_SAT) silence_cnt++;
			if (frame_cnt != TIMER_SAT) frame_cnt++;
			if (silence_cnt >= cur_timeout) begin
				if (prev_cmd != CODE_RELEASE || press_done) begin
					decode_press(CODE_RELEASE);
					prev_cmd = CODE_RELEASE;
					lamp_on  = 1'b0;
				end
				silence_cnt = '0;
			end
			if (frame_cnt >= cur_period) begin
				frame_cnt = '0;
				push_status(1'b1, HDR_0, 1'b0);
				push_status(1'b1, HDR_1, 1'b0);
				push_status(1'b1, HDR_2, 1'b0);
				push_status(1'b1, drive_word[7:0], 1'b0);
				push_status(1'b1, drive_word[15:8], 1'b1);
			end else begin
				push_status(1'b0, 8'd0, 1'b1);
			end
		end
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus side
	// -----------------------------------------------------------------------

	// Offer one transaction; predict it once acceptance at the next edge is certain
	task automatic send_item(logic func, logic [7:0] auth, logic [7:0] cmd, logic long_ok);
		bit rdy;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {7'd0, long_ok, cmd, auth};
		rdy = 1'b0;
		while (!rdy) begin
			@(negedge clk);
			rdy = (s_tready === 1'b1);
			if (rdy) predict_remote_step(func, auth, cmd, long_ok);
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
	endtask

	// Write all three registers; only called with the block idle
	task automatic program_registers(logic [7:0] key, logic [15:0] timeout,
			logic [15:0] period);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_AUTH_KEY;
		cfg_data  <= {8'd0, key};
		@(posedge clk);
		cur_key = key;
		cfg_index <= CFG_RELEASE_TIMEOUT;
		cfg_data  <= timeout;
		@(posedge clk);
		cur_timeout = timeout;
		cfg_index <= CFG_FRAME_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cur_period = period;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_code(int idx);
		case (idx)
			0:  return CODE_AUTO;
			1:  return CODE_MACHINE;
			2:  return CODE_TANK;
			3:  return CODE_BIT1;
			4:  return CODE_BIT2;
			5:  return CODE_BIT3;
			6:  return CODE_BIT4;
			7:  return CODE_BIT7;
			8:  return CODE_BIT8;
			9:  return CODE_BIT9;
			10: return CODE_BIT10;
			default: return CODE_BIT15;
		endcase
	endfunction

	// Mostly keyed presses and releases, a share of ticks, some noise
	task automatic run_random_items(int count);
		int         r;
		logic [7:0] cmd;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				send_item(FUNC_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
			end else if (r < 42) begin
				send_item(FUNC_MSG, 8'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				r = $urandom_range(9);
				if (r < 4) cmd = pick_code($urandom_range(11));
				else if (r < 7) cmd = CODE_RELEASE;
				else cmd = 8'($urandom);
				send_item(FUNC_MSG, cur_key, cmd, 1'b1);
			end
		end
		drain_results();
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	task automatic test_directed_commands();
		send_idle_pct = 0;
		stall_pct     = 0;
		program_registers(KEY_DEFAULT, 16'd2, 16'd1);
		// rejection: wrong key, then too short
		send_item(FUNC_MSG, 8'd0, CODE_AUTO, 1'b1);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_AUTO, 1'b0);
		// latch toggle, repeat, then a press while one is still held
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_AUTO, 1'b1);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_AUTO, 1'b1);
		send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_MACHINE, 1'b1);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_RELEASE, 1'b1);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_MACHINE, 1'b1);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_RELEASE, 1'b1);
		// unknown code only marks the press
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_UNKNOWN, 1'b1);
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_RELEASE, 1'b1);
		// tank latch, then silence long enough for a timeout release
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_TANK, 1'b1);
		send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
		send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
		send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
		send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
		// momentary bit shows in the next frame
		send_item(FUNC_MSG, KEY_DEFAULT, CODE_BIT15, 1'b1);
		send_item(FUNC_TICK, 8'd0, 8'd0, 1'b0);
		drain_results();
		// top key and longest timers
		program_registers(KEY_TOP, TIMER_SAT, TIMER_SAT);
		send_item(FUNC_MSG, KEY_TOP, CODE_TOP, 1'b1);
		send_item(FUNC_MSG, KEY_TOP, CODE_RELEASE, 1'b1);
		send_item(FUNC_TICK, 8'hFF, 8'hFF, 1'b1);
		send_item(FUNC_MSG, 8'd254, CODE_AUTO, 1'b1);
		drain_results();
	endtask

	task automatic test_random_no_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
		program_registers(8'h5A, 16'd1, 16'd1);
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_random_sender_idle();
		send_idle_pct = 64;
		stall_pct     = 0;
		program_registers(8'd0, 16'd4, 16'd3);
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_random_receiver_stall();
		send_idle_pct = 0;
		stall_pct     = 64;
		program_registers(8'($urandom), 16'd10, 16'd2);
		// long hold-off while the sender keeps offering
		hold_req = LONG_HOLD;
		run_random_items(PHASE_ITEMS);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct = 9;
		stall_pct     = 9;
		program_registers(8'($urandom), 16'($urandom_range(12, 1)),
			16'($urandom_range(6, 1)));
		run_random_items(PHASE_ITEMS);
	endtask

	initial begin
		reset_latch_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_random_no_idle();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// -----------------------------------------------------------------------
	// Result side
	// -----------------------------------------------------------------------

	// Drive ready: honor a pending long hold, else stall at random
	always @(posedge clk) begin : ready_driver
		int hold_left;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic void check_field(string name, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
			errors++;
		end
	endfunction

	// Sample between edges, compare once the transaction has completed
	always begin : result_checker
		logic    seen;
		status_t got;
		status_t want;
		@(negedge clk);
		seen         = (m_tvalid === 1'b1) && (m_tready === 1'b1);
		got.is_frame = m_tuser;
		got.data     = m_tdata[7:0];
		got.last     = m_tlast;
		got.led      = m_tdata[8];
		@(posedge clk);
		if (seen) begin
			if (status_q.size() == 0) begin
				$display("%0t: unexpected result expected none actual %h", $time, got);
				errors++;
			end else begin
				want = status_q.pop_front();
				check_field("is_frame", want.is_frame, got.is_frame);
				check_field("out_byte", want.data, got.data);
				check_field("last_of_run", want.last, got.last);
				check_field("indicator_led", want.led, got.led);
			end
		end
	end

	// End the run if no transaction moves on either side for too long
	always @(negedge clk) begin : watchdog
		int quiet_cycles;
		if ((s_tvalid === 1'b1 && s_tready === 1'b1)
				|| (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results pending",
				$time, quiet_cycles, status_q.size());
			$display("simulation failed");
			$finish;
		end
	end

endmodule
